// ----- hw/rtl/shcf_pkg.sv -----
// ----------------------------------------------------------------------------
// shcf_pkg
// Shared widths, command codes and types of the headphone crossfeed block.
// ----------------------------------------------------------------------------
package shcf_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	localparam int GAIN_W    = 17;
	localparam int COEF_W    = 32;
	localparam int STATE_W   = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Shared multiplier operands: coefficient or gain times data.
	localparam int A_W     = COEF_W + 1;
	localparam int INNER_W = 35;
	localparam int B_W     = INNER_W;
	localparam int P_W     = A_W + B_W;
	localparam int ACC_W   = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DIRECT_GAIN = 3'd0,
		REG_CROSS_GAIN  = 3'd1,
		REG_LOWPASS_B0  = 3'd2,
		REG_LOWPASS_B1  = 3'd3,
		REG_LOWPASS_A1  = 3'd4,
		REG_HIGHPASS_B0 = 3'd5,
		REG_HIGHPASS_B1 = 3'd6,
		REG_HIGHPASS_A1 = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		A_LP_B0,
		A_LP_B1,
		A_LP_A1,
		A_HP_B0,
		A_HP_B1,
		A_HP_A1,
		A_DG,
		A_CG
	} a_sel_t;

	typedef enum logic [3:0] {
		B_X_L,
		B_X_R,
		B_PREV_L,
		B_PREV_R,
		B_LPL,
		B_LPR,
		B_HPL,
		B_HPR,
		B_INNER_L,
		B_INNER_R
	} b_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_LOAD_RND,
		ACC_ADD,
		ACC_SUB,
		ACC_FSTORE,
		ACC_ISTORE,
		ACC_OSTORE
	} acc_op_t;

	typedef enum logic [2:0] {
		DST_LPL,
		DST_HPL,
		DST_LPR,
		DST_HPR,
		DST_L,
		DST_R
	} dst_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		dst_t    dst;
	} dp_cmd_t;

	typedef struct packed {
		logic load_x;
		logic commit;
	} dp_ctl_t;

	localparam dp_cmd_t CMD_NOP = '{a_sel: A_DG, b_sel: B_X_L, acc_op: ACC_NONE, dst: DST_L};

endpackage

// ----- hw/rtl/shcf_ctrl.sv -----
// ----------------------------------------------------------------------------
// shcf_ctrl
// Sequencer that steps the shared multiply-accumulate datapath through the
// four filters and the two output mixes of one stereo pair.
// ----------------------------------------------------------------------------
module shcf_ctrl
	import shcf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	output dp_ctl_t ctl
);

	localparam int NUM_STEPS = 28;
	localparam int STEP_W    = $clog2(NUM_STEPS + 2);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	dp_cmd_t           cmd_q;
	logic              out_valid_q;

	function automatic dp_cmd_t step_cmd(input logic [STEP_W-1:0] step);
		dp_cmd_t c;
		c = CMD_NOP;
		case (step)
			// Lowpass of the right channel into the left output.
			5'd0:  c = '{A_LP_B0, B_X_R,     ACC_LOAD,     DST_LPL};
			5'd1:  c = '{A_LP_B1, B_PREV_R,  ACC_ADD,      DST_LPL};
			5'd2:  c = '{A_LP_A1, B_LPL,     ACC_SUB,      DST_LPL};
			5'd3:  c = '{A_DG,    B_X_L,     ACC_FSTORE,   DST_LPL};
			5'd4:  c = '{A_HP_B0, B_X_L,     ACC_LOAD,     DST_HPL};
			5'd5:  c = '{A_HP_B1, B_PREV_L,  ACC_ADD,      DST_HPL};
			5'd6:  c = '{A_HP_A1, B_HPL,     ACC_SUB,      DST_HPL};
			5'd7:  c = '{A_DG,    B_X_L,     ACC_FSTORE,   DST_HPL};
			5'd8:  c = '{A_LP_B0, B_X_L,     ACC_LOAD,     DST_LPR};
			5'd9:  c = '{A_LP_B1, B_PREV_L,  ACC_ADD,      DST_LPR};
			5'd10: c = '{A_LP_A1, B_LPR,     ACC_SUB,      DST_LPR};
			5'd11: c = '{A_DG,    B_X_L,     ACC_FSTORE,   DST_LPR};
			5'd12: c = '{A_HP_B0, B_X_R,     ACC_LOAD,     DST_HPR};
			5'd13: c = '{A_HP_B1, B_PREV_R,  ACC_ADD,      DST_HPR};
			5'd14: c = '{A_HP_A1, B_HPR,     ACC_SUB,      DST_HPR};
			5'd15: c = '{A_DG,    B_X_L,     ACC_FSTORE,   DST_HPR};
			// Inner mix sums carry the rounding offset from the first product.
			5'd16: c = '{A_DG,    B_X_L,     ACC_LOAD_RND, DST_L};
			5'd17: c = '{A_CG,    B_LPL,     ACC_ADD,      DST_L};
			5'd18: c = '{A_CG,    B_HPL,     ACC_ADD,      DST_L};
			5'd19: c = '{A_DG,    B_X_L,     ACC_ISTORE,   DST_L};
			5'd20: c = '{A_DG,    B_X_R,     ACC_LOAD_RND, DST_R};
			5'd21: c = '{A_CG,    B_LPR,     ACC_ADD,      DST_R};
			5'd22: c = '{A_CG,    B_HPR,     ACC_ADD,      DST_R};
			5'd23: c = '{A_DG,    B_X_L,     ACC_ISTORE,   DST_R};
			5'd24: c = '{A_DG,    B_INNER_L, ACC_LOAD_RND, DST_L};
			5'd25: c = '{A_DG,    B_X_L,     ACC_OSTORE,   DST_L};
			5'd26: c = '{A_DG,    B_INNER_R, ACC_LOAD_RND, DST_R};
			5'd27: c = '{A_DG,    B_X_L,     ACC_OSTORE,   DST_R};
			default: c = CMD_NOP;
		endcase
		return c;
	endfunction

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd        = cmd_q;
	assign ctl.load_x = in_valid && (state_q == ST_IDLE);
	assign ctl.commit = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			cmd_q       <= CMD_NOP;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cmd_q <= CMD_NOP;
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					// Two extra steps let the last command clear both datapath stages.
					if (step_q == STEP_W'(NUM_STEPS + 1)) begin
						cmd_q   <= CMD_NOP;
						state_q <= ST_DONE;
					end else begin
						cmd_q  <= step_cmd(step_q);
						step_q <= step_q + 1'b1;
					end
				end
				ST_DONE: begin
					cmd_q <= CMD_NOP;
					if (ctl.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					cmd_q   <= CMD_NOP;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/shcf_datapath.sv -----
// ----------------------------------------------------------------------------
// shcf_datapath
// Configuration registers, filter history and one shared multiplier feeding a
// saturating 64-bit accumulator, with rounding and clamping store paths.
// ----------------------------------------------------------------------------
module shcf_datapath
	import shcf_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	input  dp_cmd_t                       cmd,
	input  dp_ctl_t                       ctl,
	input  logic signed [SAMPLE_BITS-1:0] in_left,
	input  logic signed [SAMPLE_BITS-1:0] in_right,
	output logic signed [SAMPLE_BITS-1:0] out_left,
	output logic signed [SAMPLE_BITS-1:0] out_right
);

	localparam logic signed [ACC_W:0] FILT_RND = (ACC_W+1)'(1) <<< 29;
	localparam logic signed [ACC_W-1:0] OUT_RND = ACC_W'(1) <<< 15;
	localparam logic signed [ACC_W-31:0] FILT_MAX = (ACC_W-30)'((64'sd1 <<< 31) - 64'sd1);
	localparam logic signed [ACC_W-31:0] FILT_MIN = -((ACC_W-30)'(64'sd1 <<< 31));
	localparam logic signed [ACC_W-17:0] OUT_MAX =
		(ACC_W-16)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-17:0] OUT_MIN = -((ACC_W-16)'(64'sd1 <<< (SAMPLE_BITS - 1)));

	logic        [GAIN_W-1:0]      same_gain_q;
	logic        [GAIN_W-1:0]      blend_gain_q;
	logic signed [COEF_W-1:0]      lp_b0_q, lp_b1_q, lp_a1_q;
	logic signed [COEF_W-1:0]      hp_b0_q, hp_b1_q, hp_a1_q;

	logic signed [SAMPLE_BITS-1:0] x_l_q, x_r_q;
	logic signed [SAMPLE_BITS-1:0] prev_l_q, prev_r_q;
	logic signed [STATE_W-1:0]     lpl_q, lpr_q, hpl_q, hpr_q;
	logic signed [INNER_W-1:0]     inner_l_q, inner_r_q;
	logic signed [SAMPLE_BITS-1:0] res_l_q, res_r_q;
	logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;

	logic signed [A_W-1:0]   a_op;
	logic signed [B_W-1:0]   b_op;
	logic signed [P_W-1:0]   prod;
	logic signed [ACC_W-1:0] prod_s1;
	dp_cmd_t                 cmd_s1;
	logic signed [ACC_W-1:0] acc_q;

	logic signed [ACC_W:0]    p_ext, addend, acc_sum, rnd_sum;
	logic signed [ACC_W-1:0]  acc_next, rnd_sat;
	logic signed [ACC_W-31:0] filt_sh;
	logic signed [STATE_W-1:0] filt_val;
	logic signed [ACC_W-17:0] out_sh;
	logic signed [SAMPLE_BITS-1:0] out_val;

	function automatic logic signed [ACC_W-1:0] sat_wide(input logic signed [ACC_W:0] v);
		logic signed [ACC_W-1:0] r;
		if (v[ACC_W] != v[ACC_W-1]) begin
			r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r = v[ACC_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] x_sel(input b_sel_t s,
		input logic signed [SAMPLE_BITS-1:0] xl, input logic signed [SAMPLE_BITS-1:0] xr,
		input logic signed [SAMPLE_BITS-1:0] pl, input logic signed [SAMPLE_BITS-1:0] pr);
		logic signed [SAMPLE_BITS-1:0] r;
		case (s)
			B_X_R:    r = xr;
			B_PREV_L: r = pl;
			B_PREV_R: r = pr;
			default:  r = xl;
		endcase
		return r;
	endfunction

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.a_sel)
			A_LP_B0: a_op = {lp_b0_q[COEF_W-1], lp_b0_q};
			A_LP_B1: a_op = {lp_b1_q[COEF_W-1], lp_b1_q};
			A_LP_A1: a_op = {lp_a1_q[COEF_W-1], lp_a1_q};
			A_HP_B0: a_op = {hp_b0_q[COEF_W-1], hp_b0_q};
			A_HP_B1: a_op = {hp_b1_q[COEF_W-1], hp_b1_q};
			A_HP_A1: a_op = {hp_a1_q[COEF_W-1], hp_a1_q};
			A_CG:    a_op = {{(A_W-GAIN_W){1'b0}}, blend_gain_q};
			default: a_op = {{(A_W-GAIN_W){1'b0}}, same_gain_q};
		endcase
	end

	always_comb begin
		logic signed [SAMPLE_BITS-1:0] xs;
		xs = x_sel(cmd.b_sel, x_l_q, x_r_q, prev_l_q, prev_r_q);
		case (cmd.b_sel)
			B_LPL:     b_op = {{(B_W-STATE_W){lpl_q[STATE_W-1]}}, lpl_q};
			B_LPR:     b_op = {{(B_W-STATE_W){lpr_q[STATE_W-1]}}, lpr_q};
			B_HPL:     b_op = {{(B_W-STATE_W){hpl_q[STATE_W-1]}}, hpl_q};
			B_HPR:     b_op = {{(B_W-STATE_W){hpr_q[STATE_W-1]}}, hpr_q};
			B_INNER_L: b_op = inner_l_q;
			B_INNER_R: b_op = inner_r_q;
			default:   b_op = {{(B_W-SAMPLE_BITS){xs[SAMPLE_BITS-1]}}, xs};
		endcase
	end

	assign prod = a_op * b_op;

	// Accumulate stage: every product fits in 64 signed bits.
	always_comb begin
		p_ext    = {prod_s1[ACC_W-1], prod_s1};
		addend   = (cmd_s1.acc_op == ACC_SUB) ? -p_ext : p_ext;
		acc_sum  = {acc_q[ACC_W-1], acc_q} + addend;
		acc_next = sat_wide(acc_sum);

		rnd_sum  = {acc_q[ACC_W-1], acc_q} + FILT_RND;
		rnd_sat  = sat_wide(rnd_sum);
		filt_sh  = rnd_sat[ACC_W-1:30];
		if (filt_sh > FILT_MAX) begin
			filt_val = FILT_MAX[STATE_W-1:0];
		end else if (filt_sh < FILT_MIN) begin
			filt_val = FILT_MIN[STATE_W-1:0];
		end else begin
			filt_val = filt_sh[STATE_W-1:0];
		end

		// The accumulator already holds the rounding offset of the mix.
		out_sh = acc_q[ACC_W-1:16];
		if (out_sh > OUT_MAX) begin
			out_val = OUT_MAX[SAMPLE_BITS-1:0];
		end else if (out_sh < OUT_MIN) begin
			out_val = OUT_MIN[SAMPLE_BITS-1:0];
		end else begin
			out_val = out_sh[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			same_gain_q   <= GAIN_W'(65536);
			blend_gain_q  <= '0;
			lp_b0_q       <= '0;
			lp_b1_q       <= '0;
			lp_a1_q       <= '0;
			hp_b0_q       <= '0;
			hp_b1_q       <= '0;
			hp_a1_q       <= '0;
			prev_l_q      <= '0;
			prev_r_q      <= '0;
			lpl_q         <= '0;
			lpr_q         <= '0;
			hpl_q         <= '0;
			hpr_q         <= '0;
			cmd_s1        <= CMD_NOP;
		end else begin
			cmd_s1 <= cmd;
			if (cfg_wr_en) begin
				case (cfg_reg_t'(cfg_index))
					REG_DIRECT_GAIN: same_gain_q   <= cfg_data[GAIN_W-1:0];
					REG_CROSS_GAIN:  blend_gain_q  <= cfg_data[GAIN_W-1:0];
					REG_LOWPASS_B0:  lp_b0_q       <= cfg_data[COEF_W-1:0];
					REG_LOWPASS_B1:  lp_b1_q       <= cfg_data[COEF_W-1:0];
					REG_LOWPASS_A1:  lp_a1_q       <= cfg_data[COEF_W-1:0];
					REG_HIGHPASS_B0: hp_b0_q       <= cfg_data[COEF_W-1:0];
					REG_HIGHPASS_B1: hp_b1_q       <= cfg_data[COEF_W-1:0];
					REG_HIGHPASS_A1: hp_a1_q       <= cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end
			if (cmd_s1.acc_op == ACC_FSTORE) begin
				case (cmd_s1.dst)
					DST_LPL: lpl_q <= filt_val;
					DST_HPL: hpl_q <= filt_val;
					DST_LPR: lpr_q <= filt_val;
					DST_HPR: hpr_q <= filt_val;
					default: ;
				endcase
			end
			if (ctl.commit) begin
				prev_l_q <= x_l_q;
				prev_r_q <= x_r_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod[ACC_W-1:0];
		if (ctl.load_x) begin
			x_l_q <= in_left;
			x_r_q <= in_right;
		end
		case (cmd_s1.acc_op)
			ACC_LOAD:     acc_q <= prod_s1;
			ACC_LOAD_RND: acc_q <= prod_s1 + OUT_RND;
			ACC_ADD:      acc_q <= acc_next;
			ACC_SUB:      acc_q <= acc_next;
			ACC_ISTORE: begin
				if (cmd_s1.dst == DST_R) begin
					inner_r_q <= acc_q[INNER_W+15:16];
				end else begin
					inner_l_q <= acc_q[INNER_W+15:16];
				end
			end
			ACC_OSTORE: begin
				if (cmd_s1.dst == DST_R) begin
					res_r_q <= out_val;
				end else begin
					res_l_q <= out_val;
				end
			end
			default: ;
		endcase
		if (ctl.commit) begin
			out_l_q <= res_l_q;
			out_r_q <= res_r_q;
		end
	end

	assign out_left  = out_l_q;
	assign out_right = out_r_q;

endmodule

// ----- hw/rtl/stereo_headphone_crossfeed.sv -----
// ----------------------------------------------------------------------------
// stereo_headphone_crossfeed
// One stereo pair is in flight at a time: a new pair is accepted only once the
// previous one has run its 28 multiplier steps, drained the datapath and been
// committed; the commit waits until any held output has been taken.
// A waiting output does not block the next pair from being accepted and run.
// Reset (asynchronous, active low) clears filter history, sets direct gain to
// 1.0 and every other configuration register to zero.
// ----------------------------------------------------------------------------
module stereo_headphone_crossfeed
	import shcf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [TDATA_W-1:0]   s_axis_tdata,   // left_in, right_in
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [TDATA_W-1:0]   m_axis_tdata,   // left_out, right_out
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	dp_cmd_t                       cmd;
	dp_ctl_t                       ctl;
	logic signed [SAMPLE_BITS-1:0] out_left, out_right;

	shcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.ctl       (ctl)
	);

	shcf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.ctl       (ctl),
		.in_left   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.in_right  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.out_left  (out_left),
		.out_right (out_right)
	);

	assign m_axis_tdata = TDATA_W'({out_right, out_left});

	// A finished pair never overwrites an output still waiting to be taken.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result committed over a stalled output");

	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> m_axis_tvalid)
		else $error("output not valid after commit");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a pair is in flight");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_x |-> (cmd.acc_op == ACC_NONE))
		else $error("input loaded while the datapath is busy");

endmodule

// ----- sim/stereo_headphone_crossfeed_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_headphone_crossfeed_test
// Streams stereo pairs through the crossfeed block under several gain and
// filter settings and compares each output pair with a bit-exact prediction.
// ----------------------------------------------------------------------------
module stereo_headphone_crossfeed_test
	import shcf_pkg::*;
();

	localparam int  HALF_PERIOD = 6;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  DRAIN_CYCLES = 64;
	localparam int  MAX_REPORTS = 10;

	typedef logic signed [SAMPLE_BITS-1:0] pcm_t;
	typedef logic signed [STATE_W-1:0]     history_t;
	typedef logic signed [COEF_W-1:0]      coef_t;
	typedef logic [GAIN_W-1:0]             gain_t;

	typedef struct packed {
		pcm_t right;
		pcm_t left;
	} pair_t;

	localparam pcm_t  SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam pcm_t  SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam coef_t COEF_MAX   = 32'sh7FFF_FFFF;
	localparam coef_t COEF_MIN   = 32'sh8000_0000;
	localparam int    UNITY_Q30  = 1 << 30;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	// Register copies, as they stand after reset.
	gain_t same_gain  = gain_t'(65536);
	gain_t blend_gain = '0;
	coef_t lp_b0 = '0, lp_b1 = '0, lp_a1 = '0;
	coef_t hp_b0 = '0, hp_b1 = '0, hp_a1 = '0;

	// Filter history.
	pcm_t     prev_left = '0, prev_right = '0;
	history_t lp_into_left = '0, lp_into_right = '0;
	history_t hp_left = '0, hp_right = '0;

	pair_t expected_pairs[$];
	int    error_count = 0;
	int    cycle_count = 0;
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;

	stereo_headphone_crossfeed dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // left_in, right_in
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // left_out, right_out
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic longint sat_add64(longint a, longint b);
		logic signed [64:0] wide;
		wide = a;
		wide = wide + b;
		if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (wide < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return longint'(wide);
	endfunction

	// First-order direct-form-I section: y = b0*x + b1*x1 - a1*y1, Q2.30 coefficients.
	function automatic history_t first_order_section(coef_t b0, coef_t b1, coef_t a1,
			longint x, longint x1, longint y1);
		longint acc;
		acc = longint'(b0) * x;
		acc = sat_add64(acc, longint'(b1) * x1);
		acc = sat_add64(acc, -(longint'(a1) * y1));
		acc = sat_add64(acc, longint'(1) << 29);
		acc = acc >>> 30;
		if (acc > 64'sd2147483647)
			return COEF_MAX;
		if (acc < -64'sd2147483648)
			return COEF_MIN;
		return history_t'(acc);
	endfunction

	function automatic pcm_t mix_channel(pcm_t same, history_t lp, history_t hp);
		longint inner, scaled;
		inner = longint'(same_gain) * longint'(same)
			+ longint'(blend_gain) * (longint'(lp) + longint'(hp));
		inner = (inner + 32768) >>> 16;
		// The direct gain is applied a second time on purpose.
		scaled = (longint'(same_gain) * inner + 32768) >>> 16;
		if (scaled > longint'(SAMPLE_MAX))
			return SAMPLE_MAX;
		if (scaled < longint'(SAMPLE_MIN))
			return SAMPLE_MIN;
		return pcm_t'(scaled);
	endfunction

	function automatic pair_t crossfeed_predict(pcm_t left, pcm_t right);
		pair_t result;
		lp_into_left  = first_order_section(lp_b0, lp_b1, lp_a1, right, prev_right, lp_into_left);
		hp_left       = first_order_section(hp_b0, hp_b1, hp_a1, left, prev_left, hp_left);
		lp_into_right = first_order_section(lp_b0, lp_b1, lp_a1, left, prev_left, lp_into_right);
		hp_right      = first_order_section(hp_b0, hp_b1, hp_a1, right, prev_right, hp_right);
		result.left  = mix_channel(left, lp_into_left, hp_left);
		result.right = mix_channel(right, lp_into_right, hp_right);
		prev_left  = left;
		prev_right = right;
		return result;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			REG_DIRECT_GAIN: same_gain  = value[GAIN_W-1:0];
			REG_CROSS_GAIN:  blend_gain = value[GAIN_W-1:0];
			REG_LOWPASS_B0:  lp_b0 = value;
			REG_LOWPASS_B1:  lp_b1 = value;
			REG_LOWPASS_A1:  lp_a1 = value;
			REG_HIGHPASS_B0: hp_b0 = value;
			REG_HIGHPASS_B1: hp_b1 = value;
			REG_HIGHPASS_A1: hp_a1 = value;
			default: ;
		endcase
	endtask

	task automatic send_pair(pcm_t left, pcm_t right);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {right, left};
		do @(posedge clk); while (!s_axis_tready);
		expected_pairs.push_back(crossfeed_predict(left, right));
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected pair has come back.
	task automatic drain_outputs();
		s_axis_tvalid = 1'b0;
		while (expected_pairs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic pcm_t random_sample();
		case ($urandom_range(9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return pcm_t'(int'($urandom_range(2047)) - 1024);
			default: return pcm_t'($urandom);
		endcase
	endfunction

	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= recv_idle_pct);

	// ------------------------------------------------------------------
	// Output checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what, pcm_t want, pcm_t got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin : check_output
		pair_t want;
		pcm_t got_left, got_right;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_left  = m_axis_tdata[SAMPLE_BITS-1:0];
			got_right = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			if (expected_pairs.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: output %0d/%0d with nothing expected", $realtime,
						got_left, got_right);
			end else begin
				want = expected_pairs.pop_front();
				if (got_left !== want.left)
					flag_mismatch("left_out", want.left, got_left);
				if (got_right !== want.right)
					flag_mismatch("right_out", want.right, got_right);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// After reset the block passes samples through unchanged.
	task automatic test_reset_passthrough();
		send_pair(SAMPLE_MAX, SAMPLE_MIN);
		send_pair(SAMPLE_MIN, SAMPLE_MAX);
		send_pair('0, '0);
		send_pair(pcm_t'(1), pcm_t'(-1));
		drain_outputs();
	endtask

	task automatic test_gain_extremes();
		write_reg(REG_DIRECT_GAIN, '0);
		send_pair(SAMPLE_MAX, SAMPLE_MIN);
		send_pair(SAMPLE_MIN, pcm_t'(12345));
		drain_outputs();
		// A direct gain just under 2.0, a cross gain of 1.0 and unused high bits set in the written words.
		write_reg(REG_DIRECT_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_CROSS_GAIN, 32'hABCF_0000);
		write_reg(REG_LOWPASS_B0, UNITY_Q30);
		write_reg(REG_HIGHPASS_B0, UNITY_Q30);
		send_pair(SAMPLE_MAX, SAMPLE_MAX);
		send_pair(SAMPLE_MIN, SAMPLE_MIN);
		send_pair(pcm_t'(4096), pcm_t'(-4096));
		send_pair('0, '0);
		drain_outputs();
		write_reg(REG_CROSS_GAIN, 32'h0001_FFFF);
		send_pair(SAMPLE_MAX, SAMPLE_MIN);
		send_pair(pcm_t'(-77), pcm_t'(300000));
		drain_outputs();
	endtask

	// Coefficients at their limits drive the feedback until the filter
	// outputs pin at the 32-bit limits.
	task automatic test_filter_saturation();
		write_reg(REG_DIRECT_GAIN, 32'd65536);
		write_reg(REG_CROSS_GAIN, 32'd65536);
		write_reg(REG_LOWPASS_B0, COEF_MAX);
		write_reg(REG_LOWPASS_B1, COEF_MIN);
		write_reg(REG_LOWPASS_A1, COEF_MIN);
		write_reg(REG_HIGHPASS_B0, COEF_MIN);
		write_reg(REG_HIGHPASS_B1, COEF_MAX);
		write_reg(REG_HIGHPASS_A1, COEF_MAX);
		for (int i = 0; i < 8; i++) begin
			if (i % 2 == 0)
				send_pair(SAMPLE_MAX, SAMPLE_MIN);
			else
				send_pair(SAMPLE_MIN, SAMPLE_MAX);
		end
		drain_outputs();
	endtask

	task automatic load_setting(bit wild);
		int lp_gain, hp_corner;
		if (wild) begin
			write_reg(REG_DIRECT_GAIN, $urandom);
			write_reg(REG_CROSS_GAIN, $urandom);
			write_reg(REG_LOWPASS_B0, $urandom);
			write_reg(REG_LOWPASS_B1, $urandom);
			write_reg(REG_LOWPASS_A1, $urandom);
			write_reg(REG_HIGHPASS_B0, $urandom);
			write_reg(REG_HIGHPASS_B1, $urandom);
			write_reg(REG_HIGHPASS_A1, $urandom);
		end else begin
			// Stable shelving-like sections, as a real crossfeed would use.
			lp_gain   = $urandom_range(1 << 28, 1 << 24);
			hp_corner = $urandom_range(1 << 28, 1 << 24);
			write_reg(REG_DIRECT_GAIN, $urandom_range(65536, 40000));
			write_reg(REG_CROSS_GAIN, $urandom_range(30000, 0));
			write_reg(REG_LOWPASS_B0, lp_gain);
			write_reg(REG_LOWPASS_B1, lp_gain);
			write_reg(REG_LOWPASS_A1, -(UNITY_Q30 - 2 * lp_gain));
			write_reg(REG_HIGHPASS_B0, UNITY_Q30 - hp_corner);
			write_reg(REG_HIGHPASS_B1, -(UNITY_Q30 - hp_corner));
			write_reg(REG_HIGHPASS_A1, -(UNITY_Q30 - 2 * hp_corner));
		end
	endtask

	task automatic test_random_streams();
		int send_pcts[3] = '{37, 75, 0};
		int recv_pcts[3] = '{75, 37, 0};
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = send_pcts[phase];
			recv_idle_pct = recv_pcts[phase];
			load_setting(phase == 1);
			for (int i = 0; i < 135; i++) begin
				// Let the pipeline run completely dry once per phase.
				if (i == 68)
					drain_outputs();
				send_pair(random_sample(), random_sample());
			end
			drain_outputs();
		end
	endtask

	initial begin
		send_idle_pct = 37;
		recv_idle_pct = 75;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_passthrough();
		test_gain_extremes();
		test_filter_saturation();
		test_random_streams();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_pairs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
